@@ sv/assert_macros.svh @@
// Assertion helper macros for the pheromone grid engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/pge_pkg.sv @@
// ----------------------------------------------------------------------------
// pge_pkg
// Types and codes used by the pheromone grid engine top module.
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam logic [2:0] FUNC_DEPOSIT   = 3'd0;
    localparam logic [2:0] FUNC_RADIUS    = 3'd1;
    localparam logic [2:0] FUNC_TICK      = 3'd2;
    localparam logic [2:0] FUNC_READ      = 3'd3;
    localparam logic [2:0] FUNC_CLR_LAYER = 3'd4;
    localparam logic [2:0] FUNC_CLR_ALL   = 3'd5;

    localparam logic [2:0] REG_COLS  = 3'd0;
    localparam logic [2:0] REG_ROWS  = 3'd1;
    localparam logic [2:0] REG_SHIFT = 3'd2;
    localparam logic [2:0] REG_MAX   = 3'd3;
    localparam logic [2:0] REG_MULT  = 3'd4;
    localparam logic [2:0] REG_INTV  = 3'd5;

    localparam int CFG_W = 48;
    localparam logic [15:0] DUST_LIMIT = 16'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  layer;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] radius;
        logic [15:0] amount;
        logic [9:0]  delta_ms;
    } pge_in_t;

    typedef struct packed {
        logic [15:0] intensity;
        logic [3:0]  decayed_layers;
    } pge_out_t;

    // reset value of a layer's timer
    function automatic logic [12:0] timer_start(input logic [1:0] idx);
        logic [12:0] v;
        case (idx)
            2'd0:    v = 13'd0;
            2'd1:    v = 13'd50;
            2'd2:    v = 13'd100;
            default: v = 13'd30;
        endcase
        return v;
    endfunction

endpackage

@@ sv/pge_ram.sv @@
// ----------------------------------------------------------------------------
// pge_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/pheromone_grid_engine_top.sv @@
// ----------------------------------------------------------------------------
// pheromone_grid_engine_top
// Four-layer pheromone grid: deposits, radius deposits, timed decay, reads
// and clears over one intensity RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake           word
// command   in         start & !busy       cmd (pge_in_t)
// result    out        done, one cycle     result (pge_out_t)
// config    in         cfg_we              cfg_index, cfg_data
//
// A deposit passes through setup, a walk over its single cell and drain; a read
// through setup and its read states; a radius deposit walks each cell of its box;
// a tick walks and drains each decaying layer; clears write every cell of one or
// all layers; unused functions go from setup to done. Idle follows each done.
// After reset a clearing pass writes zero to all 16384 RAM entries, one a
// cycle, with busy high. The receiver cannot stall results.
module pheromone_grid_engine_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int LAYERS   = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pge_pkg::pge_in_t          cmd,
    output logic                      done,
    output pge_pkg::pge_out_t         result,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [pge_pkg::CFG_W-1:0] cfg_data
);
    import pge_pkg::*;
    `include "assert_macros.svh"

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int AW  = LW + RW + CW;
    localparam int DEPTH = (1 << AW);
    localparam int LN  = LAYERS;

    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_SETUP = 4'd2,
                           S_WALK = 4'd3, S_DRAIN = 4'd4, S_TICK = 4'd5,
                           S_DONE = 4'd6, S_CLR = 4'd7, S_RDW = 4'd8,
                           S_RD2 = 4'd9;

    // configuration registers
    logic [6:0]  cols_cfg_reg, rows_cfg_reg;
    logic [3:0]  shift_reg;
    logic [15:0] max_reg;
    logic [47:0] mult_reg, intv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 7'd64;
            rows_cfg_reg <= 7'd64;
            shift_reg    <= 4'd4;
            max_reg      <= 16'd65280;
            mult_reg     <= 48'd253354986127155;
            intv_reg     <= 48'd8248019026920;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLS:  cols_cfg_reg <= cfg_data[6:0];
                REG_ROWS:  rows_cfg_reg <= cfg_data[6:0];
                REG_SHIFT: shift_reg    <= cfg_data[3:0];
                REG_MAX:   max_reg      <= cfg_data[15:0];
                REG_MULT:  mult_reg     <= cfg_data;
                REG_INTV:  intv_reg     <= cfg_data;
                default:   ;
            endcase
        end
    end

    // effective grid size, minus one
    logic [10:0] cols_m1, rows_m1;
    always_comb
    begin
        if (cols_cfg_reg == 7'd0)
            cols_m1 = 11'd0;
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_m1 = 11'(MAX_COLS - 1);
        else
            cols_m1 = 11'(cols_cfg_reg) - 11'd1;
        if (rows_cfg_reg == 7'd0)
            rows_m1 = 11'd0;
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_m1 = 11'(MAX_ROWS - 1);
        else
            rows_m1 = 11'(rows_cfg_reg) - 11'd1;
    end

    // position to clamped cell index
    function automatic logic [10:0] to_cell(input logic [16:0] p, input logic [3:0] sh,
                                            input logic [10:0] lim);
        logic [16:0] c;
        c = p >> sh;
        return (c > 17'(lim)) ? lim : c[10:0];
    endfunction

    // command and loop state
    logic [3:0]  state_reg, state_next;
    pge_in_t     cmd_reg;
    logic        ok_reg;
    logic [10:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [10:0] cx_reg, cy_reg;
    logic [LW:0] lay_reg;
    logic [3:0]  dec_reg;
    logic [12:0] timer_reg [LN];
    logic [AW:0] init_reg;
    logic [25:0] lim_reg;
    logic        walk_last;

    // pipeline: stage 1 holds the cell whose read data is on the RAM port
    logic        p1_v_reg, p2_v_reg;
    logic        p1_hit_reg;
    logic [AW-1:0] p1_a_reg, p2_a_reg;
    logic [11:0] mul_reg;
    logic [27:0] prod_reg;

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    pge_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // distance test for the current cell
    logic signed [28:0] dx, dy;
    logic [27:0] adx, ady;
    logic [55:0] dx_sq, dy_sq;
    logic [57:0] dsq;
    logic        in_circle;
    always_comb
    begin
        dx = (29'($unsigned({cx_reg, 1'b1})) << shift_reg) - 29'({cmd_reg.pos_x, 1'b0});
        dy = (29'($unsigned({cy_reg, 1'b1})) << shift_reg) - 29'({cmd_reg.pos_y, 1'b0});
        adx = dx[28] ? 28'(-dx) : 28'(dx);
        ady = dy[28] ? 28'(-dy) : 28'(dy);
        dx_sq = adx * adx;
        dy_sq = ady * ady;
        dsq = 58'(dx_sq) + 58'(dy_sq);
        in_circle = (cmd_reg.func != FUNC_RADIUS) || (dsq <= 58'(lim_reg));
    end

    logic [AW-1:0] cur_addr;
    assign cur_addr = AW'({lay_reg[LW-1:0], cy_reg[RW-1:0], cx_reg[CW-1:0]});
    assign walk_last = (cx_reg == x1_reg) && (cy_reg == y1_reg);

    // loop box computation
    logic [16:0] xlo, xhi, ylo, yhi;
    always_comb
    begin
        xlo = (cmd.pos_x > 16'(cmd.radius)) ? 17'(cmd.pos_x - 16'(cmd.radius)) : 17'd0;
        ylo = (cmd.pos_y > 16'(cmd.radius)) ? 17'(cmd.pos_y - 16'(cmd.radius)) : 17'd0;
        xhi = 17'(cmd.pos_x) + 17'(cmd.radius);
        yhi = 17'(cmd.pos_y) + 17'(cmd.radius);
    end

    // timer update for tick
    logic signed [13:0] tsub [LN];
    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            tsub[l] = 14'(signed'(timer_reg[l])) - 14'(cmd_reg.delta_ms);
        end
    end
    logic signed [13:0] cur_tsub;
    assign cur_tsub = tsub[lay_reg[LW-1:0]];

    logic decay_op, clear_op;
    assign decay_op = (cmd_reg.func == FUNC_TICK);
    assign clear_op = (cmd_reg.func == FUNC_CLR_LAYER) || (cmd_reg.func == FUNC_CLR_ALL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_SETUP;
            S_INIT:  if (init_reg == (AW + 1)'(DEPTH - 1)) state_next = S_IDLE;
            S_SETUP:
            begin
                case (cmd_reg.func)
                    FUNC_DEPOSIT, FUNC_RADIUS:
                        state_next = ok_reg ? S_WALK : S_DONE;
                    FUNC_READ:      state_next = ok_reg ? S_RDW : S_DONE;
                    FUNC_TICK:      state_next = S_TICK;
                    FUNC_CLR_LAYER: state_next = ok_reg ? S_CLR : S_DONE;
                    FUNC_CLR_ALL:   state_next = S_CLR;
                    default:        state_next = S_DONE;
                endcase
            end
            S_RDW:   state_next = S_RD2;
            S_RD2:   state_next = S_DONE;
            S_WALK:  if (walk_last) state_next = S_DRAIN;
            S_DRAIN: if (!p1_v_reg && !p2_v_reg)
                         state_next = decay_op ? S_TICK : S_DONE;
            S_TICK:
            begin
                if (32'(lay_reg) >= LN)
                    state_next = S_DONE;
                else if (cur_tsub <= 14'sd0)
                    state_next = S_WALK;
            end
            S_CLR:   if (walk_last && (cmd_reg.func == FUNC_CLR_LAYER ||
                                       32'(lay_reg) == LN - 1))
                         state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // registers of the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            init_reg   <= '0;
            lay_reg    <= '0;
            dec_reg    <= '0;
            x0_reg     <= '0;
            x1_reg     <= '0;
            y0_reg     <= '0;
            y1_reg     <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            mul_reg    <= '0;
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            p1_hit_reg <= 1'b0;
            p1_a_reg   <= '0;
            p2_a_reg   <= '0;
            for (int l = 0; l < LN; l++)
                timer_reg[l] <= timer_start(2'(l));
        end
        else
        begin
            state_reg  <= state_next;
            p1_v_reg   <= (state_reg == S_WALK);
            p1_hit_reg <= in_circle;
            p1_a_reg   <= cur_addr;
            p2_v_reg   <= p1_v_reg;
            p2_a_reg   <= p1_a_reg;
            case (state_reg)
                S_INIT: init_reg <= init_reg + 1'b1;
                S_IDLE:
                begin
                    lay_reg <= '0;
                    dec_reg <= '0;
                    // latch the cell box of the accepted command
                    if (start)
                    begin
                        x0_reg <= to_cell(xlo, shift_reg, cols_m1);
                        y0_reg <= to_cell(ylo, shift_reg, rows_m1);
                        if (cmd.func == FUNC_RADIUS)
                        begin
                            x1_reg <= to_cell(xhi, shift_reg, cols_m1);
                            y1_reg <= to_cell(yhi, shift_reg, rows_m1);
                        end
                        else
                        begin
                            x1_reg <= to_cell(17'(cmd.pos_x), shift_reg, cols_m1);
                            y1_reg <= to_cell(17'(cmd.pos_y), shift_reg, rows_m1);
                        end
                    end
                end
                S_SETUP:
                begin
                    if (cmd_reg.func == FUNC_CLR_LAYER || cmd_reg.func == FUNC_DEPOSIT ||
                        cmd_reg.func == FUNC_RADIUS || cmd_reg.func == FUNC_READ)
                        lay_reg <= (LW + 1)'(cmd_reg.layer);
                    if (clear_op)
                    begin
                        cx_reg <= '0;
                        cy_reg <= '0;
                        x1_reg <= 11'(MAX_COLS - 1);
                        y1_reg <= 11'(MAX_ROWS - 1);
                    end
                    else if (cmd_reg.func == FUNC_RADIUS)
                    begin
                        cx_reg <= x0_reg;
                        cy_reg <= y0_reg;
                    end
                    else
                    begin
                        cx_reg <= x1_reg;
                        cy_reg <= y1_reg;
                    end
                end
                S_WALK:
                begin
                    if (cx_reg == x1_reg)
                    begin
                        cx_reg <= x0_reg;
                        cy_reg <= cy_reg + 1'b1;
                    end
                    else
                        cx_reg <= cx_reg + 1'b1;
                end
                S_DRAIN:
                    if (!p1_v_reg && !p2_v_reg && decay_op)
                        lay_reg <= lay_reg + 1'b1;
                S_TICK:
                begin
                    if (32'(lay_reg) < LN)
                    begin
                        if (cur_tsub <= 14'sd0)
                        begin
                            timer_reg[lay_reg[LW-1:0]] <=
                                13'(intv_reg[12*(lay_reg[1:0]) +: 12]);
                            mul_reg <= mult_reg[12*(lay_reg[1:0]) +: 12];
                            if (lay_reg < 4)
                                dec_reg[lay_reg[1:0]] <= 1'b1;
                            cx_reg <= '0;
                            cy_reg <= '0;
                            x0_reg <= '0;
                            x1_reg <= 11'(MAX_COLS - 1);
                            y1_reg <= 11'(MAX_ROWS - 1);
                        end
                        else
                        begin
                            timer_reg[lay_reg[LW-1:0]] <= 13'(cur_tsub);
                            lay_reg <= lay_reg + 1'b1;
                        end
                    end
                end
                S_CLR:
                begin
                    if (cx_reg == x1_reg)
                    begin
                        cx_reg <= '0;
                        if (cy_reg == y1_reg)
                        begin
                            cy_reg  <= '0;
                            lay_reg <= lay_reg + 1'b1;
                        end
                        else
                            cy_reg <= cy_reg + 1'b1;
                    end
                    else
                        cx_reg <= cx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // capture command
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
            ok_reg  <= (32'(cmd.layer) < LAYERS);
            lim_reg <= 26'({cmd.radius, 1'b0}) * 26'({cmd.radius, 1'b0});
        end
        prod_reg <= 28'(ram_rdata) * 28'(mul_reg);
    end

    // modify stage: deposit adds saturating on read data in stage 1,
    // decay writes the registered product in stage 2
    logic [16:0] sum;
    logic [15:0] dec_val;
    assign sum = 17'(ram_rdata) + 17'(cmd_reg.amount);
    assign dec_val = prod_reg[27:12];

    // memory port control
    always_comb
    begin
        ram_raddr = (state_reg == S_WALK) ? cur_addr :
                    AW'({cmd_reg.layer, y1_reg[RW-1:0], x1_reg[CW-1:0]});
        ram_we    = 1'b0;
        ram_waddr = p1_a_reg;
        ram_wdata = 16'd0;
        if (state_reg == S_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_reg[AW-1:0];
        end
        else if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
        end
        else if (p2_v_reg && decay_op)
        begin
            ram_we    = 1'b1;
            ram_waddr = p2_a_reg;
            ram_wdata = (dec_val < DUST_LIMIT) ? 16'd0 : dec_val;
        end
        else if (p1_v_reg && !decay_op && p1_hit_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = (sum > 17'(max_reg)) ? max_reg : sum[15:0];
        end
    end

    // result
    logic [15:0] rd_val_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD2)
            rd_val_reg <= ram_rdata;
        else if (state_reg == S_SETUP)
            rd_val_reg <= 16'd0;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    always_comb
    begin
        result.intensity      = rd_val_reg;
        result.decayed_layers = dec_reg;
    end

    `CHK_NEXT(a_start_leaves_idle, clk, rst_n, start && !busy, busy, "start not taken")
    `CHK_NEXT(a_done_one_cycle, clk, rst_n, done, !done, "done held")
    `CHK_IMPL(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !ram_we, "write in idle")
endmodule
